[hdl/cycle_notation_permutation_builder_top_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the permutation builder
// Shared concurrent assertion forms, disabled while the active-high reset is high.
// ----------------------------------------------------------------------------
`ifndef CYCLE_NOTATION_PERMUTATION_BUILDER_TOP_ASSERT_SVH
`define CYCLE_NOTATION_PERMUTATION_BUILDER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define CNPB_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define CNPB_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/cnpb_pkg.sv]
// ----------------------------------------------------------------------------
// cnpb_pkg
// Types and constants of the cycle-notation permutation builder.
// ----------------------------------------------------------------------------
package cnpb_pkg;

   // Width of a point number and of the point-count register
   localparam int POINT_W = 12;

   // Point count after reset
   localparam logic [POINT_W-1:0] NUM_POINTS_RESET = 12'd2048;

   // Request operation codes
   typedef enum logic [1:0] {
      OP_START = 2'd0,
      OP_POINT = 2'd1,
      OP_CLOSE = 2'd2,
      OP_READ  = 2'd3
   } opcode_type;

   // Response status codes
   typedef enum logic [1:0] {
      STS_OK       = 2'd0,
      STS_RANGE    = 2'd1,
      STS_REPEAT   = 2'd2,
      STS_NO_CYCLE = 2'd3
   } status_type;

   // Controller states, one-hot
   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_EXEC  = 3'b010,
      ST_CLEAR = 3'b100
   } state_type;

endpackage

[hdl/cycle_notation_permutation_builder_top.sv]
// ----------------------------------------------------------------------------
// cycle_notation_permutation_builder_top
// Builds a permutation from cycle notation into an image table in memory.
// ----------------------------------------------------------------------------
// Usage:
//   A request (req_opcode, req_point) is taken at a clock edge with start high
//   and busy low. Every request yields exactly one response on rsp_status and
//   rsp_image, shown for one cycle with rsp_strobe high. The receiver cannot
//   stall; the response is gone after that cycle.
//   Point, close and read requests: the tables are read at the accept edge,
//   the result is resolved and written back in the next cycle, and the
//   response strobe comes in the cycle after that. Busy is high for one
//   cycle, so a new request is taken only once the last one is resolved;
//   the registered read port of the image and seen memories sets this.
//   Start request: a clearing pass writes the identity and clears the seen
//   marks over all MAX_POINTS entries, one entry per cycle, then responds;
//   busy stays high meanwhile.
//   Reset: the point count returns to 2048 and the same clearing pass runs
//   without a response; busy is high meanwhile. The user must write the
//   point count via csr_wr_en/csr_wr_data only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`include "cycle_notation_permutation_builder_top_assert.svh"

module cycle_notation_permutation_builder_top
   import cnpb_pkg::*;
#(
   parameter int MAX_POINTS = 2048
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_opcode,
   input  logic [POINT_W-1:0] req_point,
   output logic               rsp_strobe,
   output logic [1:0]         rsp_status,
   output logic [POINT_W-1:0] rsp_image,
   input  logic               csr_wr_en,
   input  logic [POINT_W-1:0] csr_wr_data
);

   localparam int AW = $clog2(MAX_POINTS);
   localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_POINTS - 1);
   localparam logic [POINT_W-1:0] CAP =
      (MAX_POINTS > 4095) ? {POINT_W{1'b1}} : POINT_W'(MAX_POINTS);

   // Memories, no reset: the clearing pass initializes them
   logic [POINT_W-1:0] img_mem  [MAX_POINTS];
   logic               seen_mem [MAX_POINTS];

   state_type          state_ff, state_in;
   opcode_type         op_ff, op_in;
   logic [POINT_W-1:0] point_ff, point_in;
   logic [POINT_W-1:0] first_ff, first_in;
   logic [POINT_W-1:0] prev_ff, prev_in;
   logic               open_ff, open_in;
   logic [AW-1:0]      clr_ff, clr_in;
   logic               clr_rsp_ff, clr_rsp_in;
   logic [POINT_W-1:0] num_points_ff, num_points_in;
   logic               rsp_strobe_ff, rsp_strobe_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [POINT_W-1:0] rsp_image_ff, rsp_image_in;

   logic [POINT_W-1:0] img_rd_ff;
   logic               seen_rd_ff;

   logic               accept;
   logic [AW-1:0]      rd_addr;
   logic [POINT_W-1:0] eff_n;
   logic               in_range;
   logic               img_we;
   logic [AW-1:0]      img_wa;
   logic [POINT_W-1:0] img_wd;
   logic               seen_we;
   logic [AW-1:0]      seen_wa;
   logic               seen_wd;

   assign accept  = start && (state_ff == ST_IDLE);
   assign busy    = (state_ff != ST_IDLE);
   assign rd_addr = AW'(req_point - POINT_W'(1));

   // Saturate the point count and check the held point
   assign eff_n    = (num_points_ff > CAP) ? CAP : num_points_ff;
   assign in_range = (point_ff != '0) && (point_ff <= eff_n);

   // Next-state and write-port logic
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      point_in      = point_ff;
      first_in      = first_ff;
      prev_in       = prev_ff;
      open_in       = open_ff;
      clr_in        = clr_ff;
      clr_rsp_in    = clr_rsp_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = STS_OK;
      rsp_image_in  = '0;
      img_we        = 1'b0;
      img_wa        = AW'(prev_ff - POINT_W'(1));
      img_wd        = point_ff;
      seen_we       = 1'b0;
      seen_wa       = AW'(point_ff - POINT_W'(1));
      seen_wd       = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in    = opcode_type'(req_opcode);
               point_in = req_point;
               if (opcode_type'(req_opcode) == OP_START) begin
                  clr_in     = '0;
                  clr_rsp_in = 1'b1;
                  state_in   = ST_CLEAR;
               end else begin
                  state_in = ST_EXEC;
               end
            end
         end
         ST_EXEC: begin
            rsp_strobe_in = 1'b1;
            state_in      = ST_IDLE;
            case (op_ff)
               OP_POINT: begin
                  if (!in_range) begin
                     rsp_status_in = STS_RANGE;
                  end else if (seen_rd_ff) begin
                     rsp_status_in = STS_REPEAT;
                  end else begin
                     // mark the point, then open a cycle or link from prev
                     seen_we = 1'b1;
                     if (open_ff) begin
                        img_we = 1'b1;
                     end else begin
                        first_in = point_ff;
                        open_in  = 1'b1;
                     end
                     prev_in = point_ff;
                  end
               end
               OP_CLOSE: begin
                  if (!open_ff) begin
                     rsp_status_in = STS_NO_CYCLE;
                  end else begin
                     img_we  = 1'b1;
                     img_wd  = first_ff;
                     open_in = 1'b0;
                  end
               end
               OP_READ: begin
                  if (!in_range) begin
                     rsp_status_in = STS_RANGE;
                  end else begin
                     rsp_image_in = img_rd_ff;
                  end
               end
               default: begin
                  rsp_status_in = STS_OK;
               end
            endcase
         end
         ST_CLEAR: begin
            // write identity and clear the mark, one entry per cycle
            img_we  = 1'b1;
            img_wa  = clr_ff;
            img_wd  = POINT_W'(clr_ff) + POINT_W'(1);
            seen_we = 1'b1;
            seen_wa = clr_ff;
            seen_wd = 1'b0;
            clr_in  = clr_ff + AW'(1);
            if (clr_ff == LAST_ADDR) begin
               first_in      = '0;
               prev_in       = '0;
               open_in       = 1'b0;
               rsp_strobe_in = clr_rsp_ff;
               clr_rsp_in    = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Point-count register
   assign num_points_in = csr_wr_en ? csr_wr_data : num_points_ff;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         clr_rsp_ff    <= 1'b0;
         open_ff       <= 1'b0;
         first_ff      <= '0;
         prev_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
         num_points_ff <= NUM_POINTS_RESET;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         clr_rsp_ff    <= clr_rsp_in;
         open_ff       <= open_in;
         first_ff      <= first_in;
         prev_ff       <= prev_in;
         rsp_strobe_ff <= rsp_strobe_in;
         num_points_ff <= num_points_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      point_ff      <= point_in;
      rsp_status_ff <= rsp_status_in;
      rsp_image_ff  <= rsp_image_in;
   end

   // Image memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (img_we) begin
         img_mem[img_wa] <= img_wd;
      end
      img_rd_ff <= img_mem[rd_addr];
   end

   // Seen-mark memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (seen_we) begin
         seen_mem[seen_wa] <= seen_wd;
      end
      seen_rd_ff <= seen_mem[rd_addr];
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_image  = rsp_image_ff;

   // Checks
   `CNPB_ASSERT_NEXT(a_accept_busy, clock, reset, accept, busy, "accepted request did not raise busy")
   `CNPB_ASSERT_NOW(a_rsp_idle, clock, reset, rsp_strobe_ff, state_ff == ST_IDLE, "response while busy")
   `CNPB_ASSERT_NOW(a_open_points, clock, reset, open_ff, (first_ff != '0) && (prev_ff != '0), "open cycle without points")
   `CNPB_ASSERT_NOW(a_err_image, clock, reset, rsp_strobe_ff && (rsp_status_ff != STS_OK), rsp_image_ff == '0, "error response with nonzero image")

endmodule
